### rtl/core/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5 package
// Shared types, initial chaining values, round constants and helper
// functions for the md5 digest core.
// ----------------------------------------------------------------------------
package md5_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // last zero-padded word index before the 64-bit length
    localparam logic [3:0] LAST_PAD_INDEX = 4'd13;

    localparam logic [31:0] ROUND_CONST [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_AMOUNT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // one message word as it travels from the front to the round engine
    typedef struct packed {
        logic        fin;   // last word of the final block of a message
        logic [31:0] word;
    } md5_word_t;

    typedef enum logic [2:0] {
        F_DATA,
        F_PADW,
        F_PAD,
        F_LEN_LO,
        F_LEN_HI
    } front_state_t;

    typedef enum logic [2:0] {
        B_LOAD,
        B_PREP,
        B_ROUND,
        B_ADD,
        B_OUT
    } back_state_t;

    // message word used by round r
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] low;
        logic [3:0] idx;
        low = r[3:0];
        case (r[5:4])
            2'd0:    idx = low;
            2'd1:    idx = low * 4'd5 + 4'd1;
            2'd2:    idx = low * 4'd3 + 4'd5;
            default: idx = low * 4'd7;
        endcase
        return idx;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] n);
        logic [63:0] dbl;
        dbl = {v, v} << n;
        return dbl[63:32];
    endfunction

endpackage

### rtl/core/md5_front.sv
// ----------------------------------------------------------------------------
// md5 front
// Accepts message bytes, packs them into little-endian words, keeps the
// bit count and generates the padding and length words at message end.
// ----------------------------------------------------------------------------
module md5_front import md5_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        q_push,
    output md5_word_t   q_entry,
    input  logic        q_full
);

    front_state_t state_reg, state_next;
    logic [63:0]  bit_reg, bit_next;
    logic [31:0]  part_reg, part_next;
    logic [3:0]   wcnt_reg, wcnt_next;

    logic [1:0]   lane;
    logic [3:0]   widx;
    logic [31:0]  pad_word;

    assign lane = bit_reg[4:3];
    assign widx = bit_reg[8:5];

    // bytes below the current lane are message, then the pad marker, then zeros
    always_comb begin
        case (lane)
            2'd0:    pad_word = {24'h0, PAD_BYTE};
            2'd1:    pad_word = {16'h0, PAD_BYTE, part_reg[7:0]};
            2'd2:    pad_word = {8'h0, PAD_BYTE, part_reg[15:0]};
            default: pad_word = {PAD_BYTE, part_reg[23:0]};
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        bit_next      = bit_reg;
        part_next     = part_reg;
        wcnt_next     = wcnt_reg;
        q_push        = 1'b0;
        q_entry.fin   = 1'b0;
        q_entry.word  = '0;
        s_axis_tready = (state_reg == F_DATA) && !q_full;
        case (state_reg)
            F_DATA: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    if (s_axis_tuser) begin
                        part_next[{lane, 3'b000} +: 8] = s_axis_tdata;
                        bit_next = bit_reg + 64'd8;
                        if (lane == 2'd3) begin
                            q_push       = 1'b1;
                            q_entry.word = {s_axis_tdata, part_reg[23:0]};
                        end
                    end
                    if (s_axis_tlast) begin
                        state_next = F_PADW;
                    end
                end
            end
            F_PADW: begin
                if (!q_full) begin
                    q_push       = 1'b1;
                    q_entry.word = pad_word;
                    wcnt_next    = widx + 4'd1;
                    state_next   = (widx == LAST_PAD_INDEX) ? F_LEN_LO : F_PAD;
                end
            end
            F_PAD: begin
                if (!q_full) begin
                    q_push    = 1'b1;
                    wcnt_next = wcnt_reg + 4'd1;
                    if (wcnt_reg == LAST_PAD_INDEX) begin
                        state_next = F_LEN_LO;
                    end
                end
            end
            F_LEN_LO: begin
                if (!q_full) begin
                    q_push       = 1'b1;
                    q_entry.word = bit_reg[31:0];
                    state_next   = F_LEN_HI;
                end
            end
            F_LEN_HI: begin
                if (!q_full) begin
                    q_push       = 1'b1;
                    q_entry.word = bit_reg[63:32];
                    q_entry.fin  = 1'b1;
                    bit_next     = '0;
                    state_next   = F_DATA;
                end
            end
            default: begin
                state_next = F_DATA;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_DATA;
            bit_reg   <= '0;
            wcnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            bit_reg   <= bit_next;
            wcnt_reg  <= wcnt_next;
        end
        part_reg <= part_next;
    end

endmodule

### rtl/core/md5_queue.sv
// ----------------------------------------------------------------------------
// md5 word queue
// Small fifo of message words between the front and the round engine.
// ----------------------------------------------------------------------------
module md5_queue import md5_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  md5_word_t push_entry,
    output logic      full,
    input  logic      pop,
    output md5_word_t head,
    output logic      empty
);

    md5_word_t             mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;
    logic                  do_push, do_pop;

    assign full    = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### rtl/core/md5_engine.sv
// ----------------------------------------------------------------------------
// md5 round engine
// Loads 16 words per block, runs one compression round per cycle, adds
// into the chaining words and sends the digest after the final block.
// ----------------------------------------------------------------------------
module md5_engine import md5_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  md5_word_t   q_head,
    input  logic        q_empty,
    output logic        q_pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    back_state_t state_reg, state_next;
    logic [3:0]  ld_reg, ld_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [31:0] a_reg, a_next, b_reg, b_next, c_reg, c_next, d_reg, d_next;
    logic [31:0] pre_reg, pre_next;
    logic [31:0] chain_reg [4];
    logic [31:0] chain_next [4];
    logic        fin_reg, fin_next;
    logic [1:0]  oidx_reg, oidx_next;
    logic        mv_reg, mv_next;
    logic [31:0] mword_reg, mword_next;
    logic [1:0]  midx_reg, midx_next;
    logic        mlast_reg, mlast_next;
    logic [31:0] w_mem [16];

    logic [1:0]  phase;
    logic [31:0] f;
    logic [31:0] t;
    logic [31:0] b_new;
    logic [5:0]  rnd_inc;

    assign phase   = rnd_reg[5:4];
    assign rnd_inc = rnd_reg + 6'd1;
    assign t       = pre_reg + f;
    assign b_new   = b_reg + rotl32(t, ROT_AMOUNT[{phase, rnd_reg[1:0]}]);

    always_comb begin
        case (phase)
            2'd0:    f = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2:    f = b_reg ^ c_reg ^ d_reg;
            default: f = c_reg ^ (b_reg | ~d_reg);
        endcase
    end

    assign m_axis_tvalid = mv_reg;
    assign m_axis_tdata  = {6'b0, midx_reg, mword_reg};
    assign m_axis_tlast  = mlast_reg;

    always_comb begin
        state_next = state_reg;
        ld_next    = ld_reg;
        rnd_next   = rnd_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        pre_next   = pre_reg;
        chain_next = chain_reg;
        fin_next   = fin_reg;
        oidx_next  = oidx_reg;
        mv_next    = mv_reg && !m_axis_tready;
        mword_next = mword_reg;
        midx_next  = midx_reg;
        mlast_next = mlast_reg;
        q_pop      = 1'b0;
        case (state_reg)
            B_LOAD: begin
                if (!q_empty) begin
                    q_pop   = 1'b1;
                    ld_next = ld_reg + 4'd1;
                    if (ld_reg == 4'd15) begin
                        fin_next   = q_head.fin;
                        state_next = B_PREP;
                    end
                end
            end
            B_PREP: begin
                a_next     = chain_reg[0];
                b_next     = chain_reg[1];
                c_next     = chain_reg[2];
                d_next     = chain_reg[3];
                pre_next   = chain_reg[0] + ROUND_CONST[0] + w_mem[msg_index(6'd0)];
                rnd_next   = '0;
                state_next = B_ROUND;
            end
            B_ROUND: begin
                a_next   = d_reg;
                d_next   = c_reg;
                c_next   = b_reg;
                b_next   = b_new;
                // d becomes the next round's a, so its sum is formed during the current round
                pre_next = d_reg + ROUND_CONST[rnd_inc] + w_mem[msg_index(rnd_inc)];
                rnd_next = rnd_inc;
                if (rnd_reg == 6'd63) begin
                    state_next = B_ADD;
                end
            end
            B_ADD: begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                oidx_next     = '0;
                state_next    = fin_reg ? B_OUT : B_LOAD;
            end
            B_OUT: begin
                if (!mv_reg || m_axis_tready) begin
                    mv_next    = 1'b1;
                    mword_next = chain_reg[oidx_reg];
                    midx_next  = oidx_reg;
                    mlast_next = (oidx_reg == 2'd3);
                    oidx_next  = oidx_reg + 2'd1;
                    if (oidx_reg == 2'd3) begin
                        chain_next[0] = IV_A;
                        chain_next[1] = IV_B;
                        chain_next[2] = IV_C;
                        chain_next[3] = IV_D;
                        fin_next      = 1'b0;
                        state_next    = B_LOAD;
                    end
                end
            end
            default: begin
                state_next = B_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_LOAD;
            ld_reg       <= '0;
            rnd_reg      <= '0;
            fin_reg      <= 1'b0;
            oidx_reg     <= '0;
            mv_reg       <= 1'b0;
            chain_reg[0] <= IV_A;
            chain_reg[1] <= IV_B;
            chain_reg[2] <= IV_C;
            chain_reg[3] <= IV_D;
        end else begin
            state_reg <= state_next;
            ld_reg    <= ld_next;
            rnd_reg   <= rnd_next;
            fin_reg   <= fin_next;
            oidx_reg  <= oidx_next;
            mv_reg    <= mv_next;
            chain_reg <= chain_next;
        end
        a_reg     <= a_next;
        b_reg     <= b_next;
        c_reg     <= c_next;
        d_reg     <= d_next;
        pre_reg   <= pre_next;
        mword_reg <= mword_next;
        midx_reg  <= midx_next;
        mlast_reg <= mlast_next;
        if (q_pop) begin
            w_mem[ld_reg] <= q_head.word;
        end
    end

endmodule

### rtl/core/md5_message_digest_core.sv
// ----------------------------------------------------------------------------
// md5 message digest core
// Byte-stream md5 engine: byte packing and padding in front, a word queue,
// and a one-round-per-cycle compression engine with a registered output.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one message byte per item in tdata; tuser marks tdata as
//   a real byte (clear it for an empty end item), tlast ends the message.
//   m_axis returns four digest words per message, word 0 first, tlast on
//   word 3; tdata[33:32] holds the word position.
// Throughput: the front takes one byte per cycle while it is in its data
//   state and the 16-word queue has room. The round engine loads 16 words,
//   sets up, runs 64 rounds and adds into the chaining words for each
//   64-byte block.
// End of message: after the end item the front issues up to 18 padding and
//   length words, one per cycle while the queue has room, then the last one
//   or two blocks compress and the four words leave.
// Reset: aresetn (synchronous, active low) empties the queue, clears the
//   bit count and loads the initial chaining words.
// Stalls: while m_axis_tready is low the digest holds in the output register;
//   the front keeps taking bytes until the queue fills.
// ----------------------------------------------------------------------------
module md5_message_digest_core import md5_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [33:32] word_index
    output logic        m_axis_tlast
);

    logic      push;
    md5_word_t push_entry;
    logic      q_full;
    logic      q_pop;
    md5_word_t q_head;
    logic      q_empty;

    md5_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .q_push        (push),
        .q_entry       (push_entry),
        .q_full        (q_full)
    );

    md5_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty)
    );

    md5_engine u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_head        (q_head),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

### sim/md5_message_digest_core_tb.sv
// ----------------------------------------------------------------------------
// md5 message digest core testbench
// Streams messages byte by byte into the core and checks every digest word
// against an in-bench md5 engine: a few fixed messages first (empty string,
// "abc", split end items, all-ones and all-zeros bytes), then random messages
// whose lengths cluster around the padding boundaries. Both sides idle at
// random, the receiver holds off once for a long stretch so the core backs up,
// and the sender twice waits for the core to drain completely.
// ----------------------------------------------------------------------------
module md5_message_digest_core_tb;

    localparam int STIM_ITEMS       = 410;
    localparam int SINK_HOLD_CYCLES = 1000;
    localparam int TAIL_CYCLES      = 400;

    localparam logic [31:0] INIT_A   = 32'h67452301;
    localparam logic [31:0] INIT_B   = 32'hefcdab89;
    localparam logic [31:0] INIT_C   = 32'h98badcfe;
    localparam logic [31:0] INIT_D   = 32'h10325476;
    localparam logic [7:0]  PAD_MARK = 8'h80;

    localparam logic [31:0] SINE_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int SHIFT_AMT [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    typedef struct {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_msg;
        bit         no_gap;
        bit         wait_drain;
        bit         start_hold;
    } byte_item_t;

    typedef struct {
        logic [31:0] word;
        logic [1:0]  index;
        logic        last;
    } digest_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic        s_axis_tuser = 1'b0;    // [0] has_byte
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;           // [31:0] digest_word, [33:32] word_index
    logic        m_axis_tlast;

    // predictor state
    logic [31:0] digest_chain [4];
    logic [7:0]  block_buf [64];
    logic [63:0] msg_bits;

    byte_item_t   byte_stream [$];
    digest_word_t digest_expected [$];

    byte_item_t cur_item;
    int         error_count = 0;
    int         stim_count = 0;
    bit         drain_next = 1'b0;
    logic       hold_req = 1'b0;
    int         src_wait;
    int         sink_wait;
    int         hold_left;
    bit         sink_fast = 1'b0;

    md5_message_digest_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic void digest_restart();
        digest_chain[0] = INIT_A;
        digest_chain[1] = INIT_B;
        digest_chain[2] = INIT_C;
        digest_chain[3] = INIT_D;
        msg_bits = 64'd0;
    endfunction

    function automatic void md5_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, f, t;
        int g;
        int sh;
        for (int i = 0; i < 16; i++) begin
            w[i] = {block_buf[4*i+3], block_buf[4*i+2], block_buf[4*i+1], block_buf[4*i]};
        end
        a = digest_chain[0];
        b = digest_chain[1];
        c = digest_chain[2];
        d = digest_chain[3];
        for (int r = 0; r < 64; r++) begin
            case (r / 16)
                0: begin
                    f = (b & c) | (~b & d);
                    g = r;
                end
                1: begin
                    f = (b & d) | (c & ~d);
                    g = (5 * r + 1) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = (3 * r + 5) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = (7 * r) % 16;
                end
            endcase
            t = a + f + w[g] + SINE_K[r];
            sh = SHIFT_AMT[(r / 16) * 4 + r % 4];
            t = b + ((t << sh) | (t >> (32 - sh)));
            a = d;
            d = c;
            c = b;
            b = t;
        end
        digest_chain[0] += a;
        digest_chain[1] += b;
        digest_chain[2] += c;
        digest_chain[3] += d;
    endfunction

    // take one accepted item; an end item queues the four digest words
    function automatic void digest_absorb(input byte_item_t it);
        int pos;
        logic [63:0] len;
        digest_word_t dw;
        if (it.has_byte) begin
            pos = int'(msg_bits[8:3]);
            block_buf[pos] = it.data_byte;
            msg_bits += 64'd8;
            if (pos == 63) md5_compress();
        end
        if (it.end_msg) begin
            len = msg_bits;
            pos = int'(msg_bits[8:3]);
            block_buf[pos] = PAD_MARK;
            pos++;
            // no room for the length: pad out and compress an extra block
            if (pos > 56) begin
                while (pos < 64) begin
                    block_buf[pos] = 8'h00;
                    pos++;
                end
                md5_compress();
                pos = 0;
            end
            while (pos < 56) begin
                block_buf[pos] = 8'h00;
                pos++;
            end
            for (int k = 0; k < 8; k++) block_buf[56 + k] = len[8*k +: 8];
            md5_compress();
            for (int k = 0; k < 4; k++) begin
                dw.word  = digest_chain[k];
                dw.index = k[1:0];
                dw.last  = (k == 3);
                digest_expected.push_back(dw);
            end
            digest_restart();
        end
    endfunction

    function automatic int draw_gap(input bit fast);
        return fast ? 0 : int'($urandom_range(0, 14));
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("mismatch %s: got %h, want %h", what, got, want);
    endtask

    task automatic push_item(input logic [7:0] data, input logic has, input logic last,
                             input bit burst, input bit hold);
        byte_item_t it;
        it.data_byte  = data;
        it.has_byte   = has;
        it.end_msg    = last;
        it.no_gap     = burst;
        it.wait_drain = drain_next;
        it.start_hold = hold;
        drain_next = 1'b0;
        byte_stream.push_back(it);
        if (has || last) stim_count++;
    endtask

    // fill: 0 random bytes, 1 all ones, 2 all zeros
    task automatic queue_message(input int len, input int fill, input bit burst,
                                 input bit hold, input bit noisy);
        bit split_end;
        logic [7:0] data;
        split_end = (len == 0) || ($urandom_range(0, 2) == 0);
        for (int i = 0; i < len; i++) begin
            if (noisy && $urandom_range(0, 15) == 0)
                push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, burst, 1'b0);
            case (fill)
                1:       data = 8'hff;
                2:       data = 8'h00;
                default: data = 8'($urandom_range(0, 255));
            endcase
            push_item(data, 1'b1, !split_end && (i == len - 1), burst,
                      hold && !split_end && (i == len - 1));
        end
        if (split_end)
            push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, burst, hold);
    endtask

    // sender
    always @(posedge aclk) begin
        bit fire;
        bit present;
        bit hold_now;
        fire     = s_axis_tvalid && s_axis_tready;
        present  = s_axis_tvalid && !fire;
        hold_now = fire && cur_item.start_hold;
        if (!aresetn) begin
            src_wait = 0;
            hold_req      <= 1'b0;
            s_axis_tvalid <= 1'b0;
        end else begin
            if (fire) begin
                digest_absorb(cur_item);
                src_wait = cur_item.no_gap ? 0 : draw_gap(1'b0);
            end
            if (!present) begin
                if (src_wait > 0) begin
                    src_wait--;
                end else if (byte_stream.size() > 0 &&
                             !(byte_stream[0].wait_drain && digest_expected.size() > 0)) begin
                    cur_item = byte_stream.pop_front();
                    s_axis_tdata <= cur_item.data_byte;
                    s_axis_tuser <= cur_item.has_byte;
                    s_axis_tlast <= cur_item.end_msg;
                    present = 1'b1;
                end
            end
            hold_req      <= hold_now;
            s_axis_tvalid <= present;
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        digest_word_t want;
        if (!aresetn) begin
            hold_left = 0;
            sink_wait = 0;
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (digest_expected.size() == 0) begin
                    report_mismatch("unexpected digest word", m_axis_tdata[31:0], 32'd0);
                end else begin
                    want = digest_expected.pop_front();
                    if (m_axis_tdata[31:0] !== want.word)
                        report_mismatch("digest_word", m_axis_tdata[31:0], want.word);
                    if (m_axis_tdata[33:32] !== want.index)
                        report_mismatch("word_index", 32'(m_axis_tdata[33:32]),
                                        32'(want.index));
                    if (m_axis_tlast !== want.last)
                        report_mismatch("last_word", 32'(m_axis_tlast), 32'(want.last));
                end
                sink_wait = draw_gap(sink_fast);
                if ($urandom_range(0, 7) == 0) sink_fast = !sink_fast;
            end
            if (hold_req) hold_left = SINK_HOLD_CYCLES;
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (sink_wait > 0) begin
                sink_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        bit hold_done;
        bit drain_done;
        int len;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        digest_restart();
        for (int i = 0; i < 64; i++) block_buf[i] = 8'h00;

        // empty message
        push_item(8'ha5, 1'b0, 1'b1, 1'b0, 1'b0);
        // "abc", end on the last byte
        push_item(8'h61, 1'b1, 1'b0, 1'b0, 1'b0);
        push_item(8'h62, 1'b1, 1'b0, 1'b0, 1'b0);
        push_item(8'h63, 1'b1, 1'b1, 1'b0, 1'b0);
        // "a", then an end item with no byte
        push_item(8'h61, 1'b1, 1'b0, 1'b0, 1'b0);
        push_item(8'h5a, 1'b0, 1'b1, 1'b0, 1'b0);
        // idle item between messages, then all-ones bytes
        push_item(8'hff, 1'b0, 1'b0, 1'b0, 1'b0);
        push_item(8'hff, 1'b1, 1'b0, 1'b0, 1'b0);
        push_item(8'hff, 1'b1, 1'b0, 1'b0, 1'b0);
        push_item(8'hff, 1'b1, 1'b1, 1'b0, 1'b0);
        // all-zeros bytes, started only once the core is empty
        drain_next = 1'b1;
        push_item(8'h00, 1'b1, 1'b0, 1'b0, 1'b0);
        push_item(8'h00, 1'b1, 1'b0, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
        push_item(8'h00, 1'b1, 1'b0, 1'b0, 1'b0);
        push_item(8'hff, 1'b0, 1'b1, 1'b0, 1'b0);

        while (stim_count < STIM_ITEMS) begin
            case ($urandom_range(0, 5))
                0:       len = $urandom_range(0, 3);
                1:       len = $urandom_range(54, 57);
                2:       len = $urandom_range(62, 66);
                3:       len = $urandom_range(118, 122);
                default: len = $urandom_range(0, 80);
            endcase
            if (!hold_done && stim_count >= 150) begin
                // receiver stalls once this end item is taken, while a long message streams in
                queue_message(len, 0, 1'b0, 1'b1, 1'b1);
                queue_message(200, 0, 1'b1, 1'b0, 1'b0);
                hold_done = 1'b1;
            end else begin
                if (!drain_done && stim_count >= 300) begin
                    drain_next = 1'b1;
                    drain_done = 1'b1;
                end
                queue_message(len, 0, $urandom_range(0, 3) == 0, 1'b0, 1'b1);
            end
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (byte_stream.size() > 0 || s_axis_tvalid) @(posedge aclk);
        while (digest_expected.size() > 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### md5_message_digest_core.f
rtl/core/md5_pkg.sv
rtl/core/md5_front.sv
rtl/core/md5_queue.sv
rtl/core/md5_engine.sv
rtl/core/md5_message_digest_core.sv
sim/md5_message_digest_core_tb.sv
